// ===== rtl/core/hpa_pkg.sv =====
// Shared constants, widths and the arctangent table of the hit angle core.
package hpa_pkg;

  // Field and datapath widths
  localparam int unsigned PosW   = 24;            // hit position, signed
  localparam int unsigned DistW  = 23;            // target distance, unsigned
  localparam int unsigned SqW    = 47;            // one squared coordinate
  localparam int unsigned R2W    = 48;            // x^2 + y^2
  localparam int unsigned RadW   = 32;            // sqrt((x^2 + y^2) * 2^16)
  localparam int unsigned RemW   = 36;            // square root remainder
  localparam int unsigned CordW  = 35;            // CORDIC x and y lanes
  localparam int unsigned AngW   = 28;            // angle accumulator, Q.24
  localparam int unsigned ThetaW = 14;
  localparam int unsigned PhiW   = 16;

  // Square root pipeline: two result bits per stage
  localparam int unsigned SqrtSteps     = RadW;
  localparam int unsigned SqrtPerStage  = 2;
  localparam int unsigned SqrtStages    = SqrtSteps / SqrtPerStage;

  // Latency outside the CORDIC: square, sum, root stages, prepare, output
  localparam int unsigned LatBase = SqrtStages + 4;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned AtanLen           = 24;

  localparam int unsigned AngFracShift = 11;
  localparam logic signed [AngW-1:0] HalfPiQ24 = AngW'(26353589);
  localparam int unsigned ThetaMax = 12868;
  localparam int unsigned PhiMax   = 25736;

  // atan(2^-i) in radians scaled by 2^24, rounded
  function automatic logic signed [AngW-1:0] atan_entry(input int unsigned idx);
    logic signed [AngW-1:0] val;
    case (idx)
      0:       val = AngW'(13176795);
      1:       val = AngW'(7778716);
      2:       val = AngW'(4110060);
      3:       val = AngW'(2086331);
      4:       val = AngW'(1047214);
      5:       val = AngW'(524117);
      6:       val = AngW'(262123);
      7:       val = AngW'(131069);
      8:       val = AngW'(65536);
      9:       val = AngW'(32768);
      10:      val = AngW'(16384);
      11:      val = AngW'(8192);
      12:      val = AngW'(4096);
      13:      val = AngW'(2048);
      14:      val = AngW'(1024);
      15:      val = AngW'(512);
      16:      val = AngW'(256);
      17:      val = AngW'(128);
      18:      val = AngW'(64);
      19:      val = AngW'(32);
      20:      val = AngW'(16);
      21:      val = AngW'(8);
      22:      val = AngW'(4);
      23:      val = AngW'(2);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/core/hit_position_to_polar_azimuth_core.sv =====
// Hit position to polar and azimuth angle converter, fully pipelined.
//
//  channel  | handshake               | beat content
//  ---------+-------------------------+--------------------------------------------
//  hit in   | start_i, busy_o         | x_position_i, y_position_i
//  cfg      | cfg_we_i                | cfg_wdata_i (target distance)
//  angles   | valid_o (one cycle)     | polar_angle_o, azimuth_angle_o,
//           |                         | undefined_flag_o
//
// One hit beat is taken every cycle while busy_o is low; each gives one angle beat
// through the square and sum registers, 16 two-bit square root stages, the prepare
// register, one CORDIC iteration per stage and the output register.
// busy_o is high during reset and is cleared at the first clock after it, low otherwise.
// The pipeline never stalls: valid bits follow each beat through the stages.
module hit_position_to_polar_azimuth_core #(
  parameter int unsigned CORDIC_STAGES = hpa_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [hpa_pkg::PosW-1:0]     x_position_i,
  input  logic signed [hpa_pkg::PosW-1:0]     y_position_i,
  output logic                                busy_o,
  input  logic                                cfg_we_i,
  input  logic        [hpa_pkg::DistW-1:0]    cfg_wdata_i,
  output logic                                valid_o,
  output logic        [hpa_pkg::ThetaW-1:0]   polar_angle_o,
  output logic signed [hpa_pkg::PhiW-1:0]     azimuth_angle_o,
  output logic                                undefined_flag_o
);

  localparam int unsigned PosW  = hpa_pkg::PosW;
  localparam int unsigned SqW   = hpa_pkg::SqW;
  localparam int unsigned R2W   = hpa_pkg::R2W;
  localparam int unsigned RadW  = hpa_pkg::RadW;
  localparam int unsigned RemW  = hpa_pkg::RemW;
  localparam int unsigned CordW = hpa_pkg::CordW;
  localparam int unsigned AngW  = hpa_pkg::AngW;
  localparam int unsigned NSq   = hpa_pkg::SqrtStages;
  localparam int unsigned NPer  = hpa_pkg::SqrtPerStage;
  localparam int unsigned RndW  = AngW + 1;
  localparam int unsigned QW    = RndW - hpa_pkg::AngFracShift;

  logic busy_q;
  logic accept;
  logic [hpa_pkg::DistW-1:0] dist_q;

  // Hold busy through reset, clear it at the first clock after
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign accept = start_i & ~busy_q;
  assign busy_o = busy_q;

  // Distance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= '0;
    end else if (cfg_we_i) begin
      dist_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------- squares
  logic signed [2*PosW-1:0] x_sq_d, y_sq_d;
  logic                     m_vld_q;
  logic signed [PosW-1:0]   m_x_q, m_y_q;
  logic [SqW-1:0]           m_x2_q, m_y2_q;

  assign x_sq_d = x_position_i * x_position_i;
  assign y_sq_d = y_position_i * y_position_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    m_x_q  <= x_position_i;
    m_y_q  <= y_position_i;
    m_x2_q <= x_sq_d[SqW-1:0];
    m_y2_q <= y_sq_d[SqW-1:0];
  end

  // ---------------------------------------------------------------- sum
  logic                   s_vld_q;
  logic signed [PosW-1:0] s_x_q, s_y_q;
  logic [R2W-1:0]         s_r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s_x_q  <= m_x_q;
    s_y_q  <= m_y_q;
    s_r2_q <= {1'b0, m_x2_q} + {1'b0, m_y2_q};
  end

  // ---------------------------------------------------------------- square root
  // Digit-by-digit floor root of r2 * 2^16, two result bits per stage.
  logic                   sq_vld_q  [NSq];
  logic signed [PosW-1:0] sq_x_q    [NSq];
  logic signed [PosW-1:0] sq_y_q    [NSq];
  logic [R2W-1:0]         sq_r2_q   [NSq];
  logic [RemW-1:0]        sq_rem_q  [NSq];
  logic [RadW-1:0]        sq_root_q [NSq];

  for (genvar k = 0; k < NSq; k++) begin : g_sqrt
    logic                   in_vld;
    logic signed [PosW-1:0] in_x, in_y;
    logic [R2W-1:0]         in_r2;
    logic [RemW-1:0]        in_rem, rem_d;
    logic [RadW-1:0]        in_root, root_d;

    if (k == 0) begin : g_first
      assign in_vld  = s_vld_q;
      assign in_x    = s_x_q;
      assign in_y    = s_y_q;
      assign in_r2   = s_r2_q;
      assign in_rem  = '0;
      assign in_root = '0;
    end else begin : g_next
      assign in_vld  = sq_vld_q[k-1];
      assign in_x    = sq_x_q[k-1];
      assign in_y    = sq_y_q[k-1];
      assign in_r2   = sq_r2_q[k-1];
      assign in_rem  = sq_rem_q[k-1];
      assign in_root = sq_root_q[k-1];
    end

    // Bring down two radicand bits, subtract the trial value when it fits
    always_comb begin
      logic [R2W+15:0] rad;
      logic [RemW-1:0] trial;
      rad    = {in_r2, 16'b0};
      rem_d  = in_rem;
      root_d = in_root;
      for (int j = 0; j < NPer; j++) begin
        rem_d = {rem_d[RemW-3:0], rad[R2W+15-2*(k*NPer+j) -: 2]};
        trial = {{(RemW-RadW-2){1'b0}}, root_d, 2'b01};
        if (rem_d >= trial) begin
          rem_d  = rem_d - trial;
          root_d = {root_d[RadW-2:0], 1'b1};
        end else begin
          root_d = {root_d[RadW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else begin
        sq_vld_q[k] <= in_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_x_q[k]    <= in_x;
      sq_y_q[k]    <= in_y;
      sq_r2_q[k]   <= in_r2;
      sq_rem_q[k]  <= rem_d;
      sq_root_q[k] <= root_d;
    end
  end

  // ---------------------------------------------------------------- prepare
  logic                    p_vld_q, p_und_q, p_org_q;
  logic signed [CordW-1:0] p_tx_q, p_ty_q, p_px_q, p_py_q;
  logic signed [AngW-1:0]  p_pz_q;
  logic signed [CordW-1:0] vx_d, vy_d, px_d, py_d;
  logic signed [AngW-1:0]  pz_d;
  logic                    org_d;

  assign org_d = (sq_x_q[NSq-1] == '0) && (sq_y_q[NSq-1] == '0);
  assign vx_d  = {{(CordW-PosW-8){sq_x_q[NSq-1][PosW-1]}}, sq_x_q[NSq-1], 8'b0};
  assign vy_d  = {{(CordW-PosW-8){sq_y_q[NSq-1][PosW-1]}}, sq_y_q[NSq-1], 8'b0};

  // Turn a left half plane vector by a quarter turn into the right half
  always_comb begin
    px_d = vx_d;
    py_d = vy_d;
    pz_d = '0;
    if (vx_d < 0) begin
      if (vy_d >= 0) begin
        px_d = vy_d;
        py_d = -vx_d;
        pz_d = hpa_pkg::HalfPiQ24;
      end else begin
        px_d = -vy_d;
        py_d = vx_d;
        pz_d = -hpa_pkg::HalfPiQ24;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= sq_vld_q[NSq-1];
    end
  end

  always_ff @(posedge clk_i) begin
    p_org_q <= org_d;
    p_und_q <= org_d && (dist_q == '0);
    p_tx_q  <= {{(CordW-hpa_pkg::DistW-8){1'b0}}, dist_q, 8'b0};
    p_ty_q  <= {{(CordW-RadW){1'b0}}, sq_root_q[NSq-1]};
    p_px_q  <= px_d;
    p_py_q  <= py_d;
    p_pz_q  <= pz_d;
  end

  // ---------------------------------------------------------------- CORDIC
  // Two vectoring lanes side by side, one iteration per stage.
  logic                    c_vld_q [CORDIC_STAGES];
  logic                    c_und_q [CORDIC_STAGES];
  logic                    c_org_q [CORDIC_STAGES];
  logic signed [CordW-1:0] c_tx_q  [CORDIC_STAGES];
  logic signed [CordW-1:0] c_ty_q  [CORDIC_STAGES];
  logic signed [AngW-1:0]  c_tz_q  [CORDIC_STAGES];
  logic signed [CordW-1:0] c_px_q  [CORDIC_STAGES];
  logic signed [CordW-1:0] c_py_q  [CORDIC_STAGES];
  logic signed [AngW-1:0]  c_pz_q  [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    localparam logic signed [AngW-1:0] Atan = hpa_pkg::atan_entry(i);
    logic                    in_vld, in_und, in_org;
    logic signed [CordW-1:0] in_tx, in_ty, in_px, in_py;
    logic signed [AngW-1:0]  in_tz, in_pz;
    logic signed [CordW-1:0] tx_d, ty_d, px_d, py_d;
    logic signed [AngW-1:0]  tz_d, pz_d;

    if (i == 0) begin : g_first
      assign in_vld = p_vld_q;
      assign in_und = p_und_q;
      assign in_org = p_org_q;
      assign in_tx  = p_tx_q;
      assign in_ty  = p_ty_q;
      assign in_tz  = '0;
      assign in_px  = p_px_q;
      assign in_py  = p_py_q;
      assign in_pz  = p_pz_q;
    end else begin : g_next
      assign in_vld = c_vld_q[i-1];
      assign in_und = c_und_q[i-1];
      assign in_org = c_org_q[i-1];
      assign in_tx  = c_tx_q[i-1];
      assign in_ty  = c_ty_q[i-1];
      assign in_tz  = c_tz_q[i-1];
      assign in_px  = c_px_q[i-1];
      assign in_py  = c_py_q[i-1];
      assign in_pz  = c_pz_q[i-1];
    end

    // Rotate toward the x axis: clockwise when y is not negative
    always_comb begin
      if (in_ty >= 0) begin
        tx_d = in_tx + (in_ty >>> i);
        ty_d = in_ty - (in_tx >>> i);
        tz_d = in_tz + Atan;
      end else begin
        tx_d = in_tx - (in_ty >>> i);
        ty_d = in_ty + (in_tx >>> i);
        tz_d = in_tz - Atan;
      end
      if (in_py >= 0) begin
        px_d = in_px + (in_py >>> i);
        py_d = in_py - (in_px >>> i);
        pz_d = in_pz + Atan;
      end else begin
        px_d = in_px - (in_py >>> i);
        py_d = in_py + (in_px >>> i);
        pz_d = in_pz - Atan;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_vld_q[i] <= 1'b0;
      end else begin
        c_vld_q[i] <= in_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      c_und_q[i] <= in_und;
      c_org_q[i] <= in_org;
      c_tx_q[i]  <= tx_d;
      c_ty_q[i]  <= ty_d;
      c_tz_q[i]  <= tz_d;
      c_px_q[i]  <= px_d;
      c_py_q[i]  <= py_d;
      c_pz_q[i]  <= pz_d;
    end
  end

  // ---------------------------------------------------------------- output
  logic signed [RndW-1:0]           t_sum, p_sum;
  logic signed [QW-1:0]             t_rnd, p_rnd;
  logic [hpa_pkg::ThetaW-1:0]       theta_d;
  logic signed [hpa_pkg::PhiW-1:0]  phi_d;
  logic                             o_vld_q;

  // Round to 13 fraction bits, then clamp to the angle range
  assign t_sum = RndW'(c_tz_q[CORDIC_STAGES-1]) + RndW'(1 << (hpa_pkg::AngFracShift - 1));
  assign p_sum = RndW'(c_pz_q[CORDIC_STAGES-1]) + RndW'(1 << (hpa_pkg::AngFracShift - 1));
  assign t_rnd = t_sum[RndW-1:hpa_pkg::AngFracShift];
  assign p_rnd = p_sum[RndW-1:hpa_pkg::AngFracShift];

  always_comb begin
    if (c_und_q[CORDIC_STAGES-1] || t_rnd < 0) begin
      theta_d = '0;
    end else if (t_rnd > QW'(hpa_pkg::ThetaMax)) begin
      theta_d = hpa_pkg::ThetaW'(hpa_pkg::ThetaMax);
    end else begin
      theta_d = t_rnd[hpa_pkg::ThetaW-1:0];
    end
  end

  always_comb begin
    if (c_org_q[CORDIC_STAGES-1]) begin
      phi_d = '0;
    end else if (p_rnd > $signed(QW'(hpa_pkg::PhiMax))) begin
      phi_d = hpa_pkg::PhiW'(hpa_pkg::PhiMax);
    end else if (p_rnd < -$signed(QW'(hpa_pkg::PhiMax))) begin
      phi_d = -hpa_pkg::PhiW'(hpa_pkg::PhiMax);
    end else begin
      phi_d = p_rnd[hpa_pkg::PhiW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else begin
      o_vld_q <= c_vld_q[CORDIC_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    polar_angle_o    <= theta_d;
    azimuth_angle_o  <= phi_d;
    undefined_flag_o <= c_und_q[CORDIC_STAGES-1];
  end

  assign valid_o = o_vld_q;

endmodule

// ===== rtl/core/hpa_checker.sv =====
// Port-level checks of the hit angle core, bound to its top level.
module hpa_checker #(
  parameter int unsigned CORDIC_STAGES = hpa_pkg::CORDIC_STAGES_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic                               valid_o,
  input logic        [hpa_pkg::ThetaW-1:0]  polar_angle_o,
  input logic signed [hpa_pkg::PhiW-1:0]    azimuth_angle_o,
  input logic                               undefined_flag_o
);

  localparam int unsigned Lat = CORDIC_STAGES + hpa_pkg::LatBase;

  // Every accepted hit beat gives an angle beat once it has passed through the pipeline
  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Lat valid_o)
    else $error("accepted hit beat gave no angle beat");

  // No angle beat without an accepted hit beat
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, Lat))
    else $error("angle beat without an accepted hit beat");

  // An undefined direction reports both angles as zero
  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && undefined_flag_o |-> polar_angle_o == '0 && azimuth_angle_o == '0)
    else $error("undefined beat with nonzero angle");

  // Angles stay within their clamp limits
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> polar_angle_o <= hpa_pkg::ThetaW'(hpa_pkg::ThetaMax)
             && azimuth_angle_o <= $signed(hpa_pkg::PhiW'(hpa_pkg::PhiMax))
             && azimuth_angle_o >= -$signed(hpa_pkg::PhiW'(hpa_pkg::PhiMax)))
    else $error("angle out of range");

endmodule

bind hit_position_to_polar_azimuth_core hpa_checker #(
  .CORDIC_STAGES(CORDIC_STAGES)
) u_hpa_checker (.*);
